@@ rtl/core/nss_pkg.sv @@
package nss_pkg;

    localparam int COORD_BITS       = 16;
    localparam int DEF_MAX_SEGMENTS = 256;

    // Widths of the distance arithmetic, all following from the coordinate width.
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int WSQ_W  = 2 * COORD_BITS;

    localparam int COUNT_W = 9;
    localparam int IDX_W   = 8;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        logic [COORD_BITS-1:0] w;
        t_coord                ey;
        t_coord                ex;
        t_coord                sy;
        t_coord                sx;
    } t_seg;

    // Side information that travels alongside the perpendicular division.
    typedef struct packed {
        logic             perp;
        logic [SUM_W-1:0] ep;
        logic [WSQ_W-1:0] wsq;
        logic [SUM_W-1:0] nn;
    } t_dmeta;

    typedef struct packed {
        logic             valid;
        logic             hit;
        logic [SUM_W-1:0] dsq;
    } t_dres;

endpackage

@@ rtl/core/nss_dist.sv @@
module nss_dist (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  nss_pkg::t_seg  i_seg,
    input  nss_pkg::t_coord i_px,
    input  nss_pkg::t_coord i_py,
    output nss_pkg::t_dres o_res
);
    import nss_pkg::*;

    localparam int HALF_W = (SUM_W + 1) / 2;
    localparam int HI_W   = SUM_W - HALF_W;
    localparam int NUM_W  = 2 * SUM_W;
    localparam int QB     = SUM_W;

    // Stage 1: differences.
    logic                     r1_vld;
    logic signed [DIFF_W-1:0] r1_nx, r1_ny, r1_pax, r1_pay, r1_bpx, r1_bpy;
    logic [COORD_BITS-1:0]    r1_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= i_valid;
        end
        r1_nx  <= DIFF_W'(i_seg.ex) - DIFF_W'(i_seg.sx);
        r1_ny  <= DIFF_W'(i_seg.ey) - DIFF_W'(i_seg.sy);
        r1_pax <= DIFF_W'(i_seg.sx) - DIFF_W'(i_px);
        r1_pay <= DIFF_W'(i_seg.sy) - DIFF_W'(i_py);
        r1_bpx <= DIFF_W'(i_px) - DIFF_W'(i_seg.ex);
        r1_bpy <= DIFF_W'(i_py) - DIFF_W'(i_seg.ey);
        r1_w   <= i_seg.w;
    end

    // Stage 2: products.
    logic                     r2_vld;
    logic signed [PROD_W-1:0] r2_c1, r2_c2, r2_d1, r2_d2, r2_n1, r2_n2;
    logic signed [PROD_W-1:0] r2_x1, r2_x2, r2_a1, r2_a2, r2_b1, r2_b2;
    logic [WSQ_W-1:0]         r2_wsq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        r2_c1  <= r1_nx * r1_pax;
        r2_c2  <= r1_ny * r1_pay;
        r2_d1  <= r1_nx * r1_bpx;
        r2_d2  <= r1_ny * r1_bpy;
        r2_n1  <= r1_nx * r1_nx;
        r2_n2  <= r1_ny * r1_ny;
        r2_x1  <= r1_nx * r1_pay;
        r2_x2  <= r1_ny * r1_pax;
        r2_a1  <= r1_pax * r1_pax;
        r2_a2  <= r1_pay * r1_pay;
        r2_b1  <= r1_bpx * r1_bpx;
        r2_b2  <= r1_bpy * r1_bpy;
        r2_wsq <= WSQ_W'(r1_w) * WSQ_W'(r1_w);
    end

    // Stage 3: dot products and the choice between ends and perpendicular foot.
    logic signed [SUM_W-1:0] s3_c, s3_dd, s3_nn, s3_cr, s3_paa, s3_bpp;
    t_dmeta                  s3_meta;
    logic                    r3_vld;
    t_dmeta                  r3_meta;
    logic signed [SUM_W-1:0] r3_cr;

    always_comb begin
        s3_c   = SUM_W'(r2_c1) + SUM_W'(r2_c2);
        s3_dd  = SUM_W'(r2_d1) + SUM_W'(r2_d2);
        s3_nn  = SUM_W'(r2_n1) + SUM_W'(r2_n2);
        s3_cr  = SUM_W'(r2_x1) - SUM_W'(r2_x2);
        s3_paa = SUM_W'(r2_a1) + SUM_W'(r2_a2);
        s3_bpp = SUM_W'(r2_b1) + SUM_W'(r2_b2);
        s3_meta.wsq = r2_wsq;
        s3_meta.nn  = s3_nn;
        // A zero-length segment is measured to its start point.
        if (s3_nn == 0 || s3_c > 0) begin
            s3_meta.perp = 1'b0;
            s3_meta.ep   = s3_paa;
        end else if (s3_dd > 0) begin
            s3_meta.perp = 1'b0;
            s3_meta.ep   = s3_bpp;
        end else begin
            s3_meta.perp = 1'b1;
            s3_meta.ep   = s3_paa;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
        r3_meta <= s3_meta;
        r3_cr   <= s3_cr;
    end

    // Stage 4: magnitude of the cross product.
    logic             r4_vld;
    t_dmeta           r4_meta;
    logic [SUM_W-1:0] r4_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= r3_vld;
        end
        r4_meta <= r3_meta;
        r4_mag  <= r3_cr[SUM_W-1] ? SUM_W'(-r3_cr) : SUM_W'(r3_cr);
    end

    // Stage 5: the square is split into three narrow partial products.
    logic                     r5_vld;
    t_dmeta                   r5_meta;
    logic [2*HALF_W-1:0]      r5_ll;
    logic [HI_W+HALF_W-1:0]   r5_lh;
    logic [2*HI_W-1:0]        r5_hh;
    logic [HI_W-1:0]          s5_ah;
    logic [HALF_W-1:0]        s5_al;

    assign s5_ah = r4_mag[SUM_W-1:HALF_W];
    assign s5_al = r4_mag[HALF_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else begin
            r5_vld <= r4_vld;
        end
        r5_meta <= r4_meta;
        r5_ll   <= (2*HALF_W)'(s5_al) * (2*HALF_W)'(s5_al);
        r5_lh   <= (HI_W+HALF_W)'(s5_ah) * (HI_W+HALF_W)'(s5_al);
        r5_hh   <= (2*HI_W)'(s5_ah) * (2*HI_W)'(s5_ah);
    end

    // Stage 6 sums the partial products into the dividend and loads the divider.
    logic [NUM_W-1:0] s6_num;

    assign s6_num = (NUM_W'(r5_hh) << (2*HALF_W)) + (NUM_W'(r5_lh) << (HALF_W+1))
                  + NUM_W'(r5_ll);

    logic             d_vld  [QB+1];
    t_dmeta           d_meta [QB+1];
    logic [SUM_W-1:0] d_rem  [QB+1];
    logic [QB-1:0]    d_low  [QB+1];
    logic [QB-1:0]    d_q    [QB+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            d_vld[0] <= 1'b0;
        end else begin
            d_vld[0] <= r5_vld;
        end
        d_meta[0] <= r5_meta;
        d_rem[0]  <= s6_num[NUM_W-1:QB];
        d_low[0]  <= s6_num[QB-1:0];
        d_q[0]    <= '0;
    end

    // Restoring division, one quotient bit per stage. The quotient never exceeds
    // the squared distance to the start point, so the high half starts below nn.
    for (genvar k = 0; k < QB; k++) begin : g_div
        logic [SUM_W:0] t;
        logic           ge;

        assign t  = {d_rem[k], d_low[k][QB-1]};
        assign ge = t >= {1'b0, d_meta[k].nn};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                d_vld[k+1] <= 1'b0;
            end else begin
                d_vld[k+1] <= d_vld[k];
            end
            d_meta[k+1] <= d_meta[k];
            d_rem[k+1]  <= ge ? SUM_W'(t - {1'b0, d_meta[k].nn}) : t[SUM_W-1:0];
            d_low[k+1]  <= d_low[k] << 1;
            d_q[k+1]    <= {d_q[k][QB-2:0], ge};
        end
    end

    logic [SUM_W-1:0] s_dist;
    t_dres            r_res;

    assign s_dist = d_meta[QB].perp ? d_q[QB] : d_meta[QB].ep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res.valid <= 1'b0;
        end else begin
            r_res.valid <= d_vld[QB];
        end
        r_res.hit <= s_dist <= SUM_W'(d_meta[QB].wsq);
        r_res.dsq <= s_dist;
    end

    assign o_res = r_res;

endmodule

@@ rtl/core/nearest_segment_search.sv @@
// Nearest segment search. A write beat (tuser = 0) stores one segment in the table.
// A query beat (tuser = 1) searches entries 0 to segment_count-1 (capped at
// MAX_SEGMENTS) and returns one result beat: found, the index of the first entry
// with the strictly smallest squared distance among those within their width, and
// that squared distance. The table memory is read one entry per cycle, and the
// distance pipeline has six arithmetic stages, a 35-stage divider for the
// perpendicular term and a compare. No beat is accepted while a query runs; a
// finished result waits in the output register while the next beat is taken. An
// entry that was never written returns an undefined result when searched.
// segment_count is written through the configuration channel; the user must write
// it only while the block is idle, which the block itself does not enforce.
module nearest_segment_search #(
    parameter int MAX_SEGMENTS = nss_pkg::DEF_MAX_SEGMENTS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [8:0]   i_cfg_data,     // segment_count
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // entry_index, seg_start_x, seg_start_y, seg_end_x, seg_end_y, seg_width,
    // point_x, point_y
    input  logic [119:0] s_axis_tdata,
    input  logic [0:0]   s_axis_tuser,   // opcode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [47:0]  m_axis_tdata,   // segment_index, distance_sq, zero fill
    output logic [0:0]   m_axis_tuser    // found
);
    import nss_pkg::*;

    localparam int AW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int LW = (CW > COUNT_W) ? CW : COUNT_W;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_WAIT  = 4'b0010,
        S_WALK  = 4'b0100,
        S_DRAIN = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [COUNT_W-1:0] r_count;
    logic [LW-1:0]      r_limit, n_limit, r_addr, r_ret;
    t_coord             r_px, r_py;
    logic               r_rd_vld;
    t_seg               r_rd_data;
    logic               r_hit;
    logic [SUM_W-1:0]   r_best;
    logic [AW-1:0]      r_bidx;
    logic               r_out_valid, r_out_found;
    logic [IDX_W-1:0]   r_out_idx;
    logic [SUM_W-1:0]   r_out_dist;

    t_seg               wr_seg;
    logic [AW+IDX_W-1:0] wr_ext;
    logic               s_fire, wr_en, out_free, last_res, upd;
    logic               load_empty, load_res, f_hit;
    logic [SUM_W-1:0]   f_best;
    logic [AW-1:0]      f_idx;
    logic [AW+IDX_W-1:0] f_ext;
    t_dres              res;

    logic [$bits(t_seg)-1:0] mem [MAX_SEGMENTS];

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    assign wr_seg.sx = s_axis_tdata[23:8];
    assign wr_seg.sy = s_axis_tdata[39:24];
    assign wr_seg.ex = s_axis_tdata[55:40];
    assign wr_seg.ey = s_axis_tdata[71:56];
    assign wr_seg.w  = s_axis_tdata[87:72];
    assign wr_ext    = {{AW{1'b0}}, s_axis_tdata[7:0]};
    assign wr_en     = s_fire && (s_axis_tuser[0] == OP_WRITE)
                    && (32'(s_axis_tdata[7:0]) < MAX_SEGMENTS);

    assign n_limit = (32'(r_count) > MAX_SEGMENTS) ? LW'(MAX_SEGMENTS) : LW'(r_count);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_ext[AW-1:0]] <= wr_seg;
        end
        if (r_state == S_WALK) begin
            r_rd_data <= mem[r_addr[AW-1:0]];
        end
    end

    nss_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_rd_vld),
        .i_seg   (r_rd_data),
        .i_px    (r_px),
        .i_py    (r_py),
        .o_res   (res)
    );

    assign out_free = !r_out_valid || m_axis_tready;
    assign last_res = res.valid && (r_ret == LW'(r_limit - 1'b1));
    assign upd      = res.valid && res.hit && (!r_hit || res.dsq < r_best);
    assign f_hit    = r_hit || upd;
    assign f_best   = upd ? res.dsq : r_best;
    assign f_idx    = upd ? r_ret[AW-1:0] : r_bidx;
    assign f_ext    = {{IDX_W{1'b0}}, f_idx};

    assign load_empty = (r_state == S_WAIT) && out_free && (r_limit == '0);
    assign load_res   = (r_state == S_DRAIN) && last_res;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_fire && s_axis_tuser[0] == OP_QUERY) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (out_free) begin
                    n_state = (r_limit == '0) ? S_IDLE : S_WALK;
                end
            end
            S_WALK: begin
                if (r_addr == LW'(r_limit - 1'b1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (last_res) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == S_WALK);
            if (i_cfg_valid) begin
                r_count <= i_cfg_data;
            end
            if (load_empty || load_res) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end

        if (s_fire && s_axis_tuser[0] == OP_QUERY) begin
            r_px    <= s_axis_tdata[103:88];
            r_py    <= s_axis_tdata[119:104];
            r_limit <= n_limit;
        end

        if (r_state == S_WAIT) begin
            r_addr <= '0;
            r_ret  <= '0;
            r_hit  <= 1'b0;
        end else begin
            if (r_state == S_WALK) begin
                r_addr <= r_addr + 1'b1;
            end
            if (res.valid) begin
                r_ret <= r_ret + 1'b1;
            end
            if (upd) begin
                r_hit  <= 1'b1;
                r_best <= res.dsq;
                r_bidx <= r_ret[AW-1:0];
            end
        end

        if (load_empty || load_res) begin
            r_out_found <= load_res && f_hit;
            r_out_idx   <= (load_res && f_hit) ? f_ext[IDX_W-1:0] : '0;
            r_out_dist  <= (load_res && f_hit) ? f_best : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_found;
    assign m_axis_tdata  = {5'b0, r_out_dist, r_out_idx};

endmodule

@@ rtl/core/nss_checker.sv @@
module nss_checker #(
    parameter int MAX_SEGMENTS = nss_pkg::DEF_MAX_SEGMENTS
) (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [0:0]   s_axis_tuser,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [47:0]  m_axis_tdata,
    input logic [0:0]   m_axis_tuser
);
    import nss_pkg::*;

    logic s_fire;

    assign s_fire = s_axis_tvalid && s_axis_tready;

    // A result beat that is not taken stays as it is.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // A miss reports zero index and zero distance.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("miss with non-zero payload");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> 32'(m_axis_tdata[7:0]) < MAX_SEGMENTS)
        else $error("segment index beyond table");

    // A write beat produces no result.
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire && s_axis_tuser[0] == OP_WRITE && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result after a write beat");

    // The input side closes while a query is searched.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire && s_axis_tuser[0] == OP_QUERY |=> !s_axis_tready)
        else $error("beat accepted during a query");

endmodule

bind nearest_segment_search nss_checker #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_nss_checker (.*);
